FILE: hdl/tcf_pkg.sv
// Package for the tilt complementary filter: widths, CORDIC angle table,
// controller state and command types. No dependencies.
package tcf_pkg;

  localparam int CordicSteps = 16;
  localparam int StepW = 5;
  localparam int AngleFracBits = 16;
  localparam int TableFrac = 24;
  localparam int BlendOne = 65536;

  localparam logic [1:0] RegGyroGain = 2'd0;
  localparam logic [1:0] RegBlendAlpha = 2'd1;
  localparam logic [1:0] RegGateLow = 2'd2;
  localparam logic [1:0] RegGateHigh = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE, ST_INTEG, ST_GATE, ST_CSETUP, ST_CITER, ST_BLEND, ST_OUT
  } tcf_state_t;

  typedef struct packed {
    logic load;
    logic integ;
    logic gate;
    logic csetup;
    logic citer;
    logic blend;
    logic [StepW-1:0] step;
  } tcf_cmd_t;

  typedef struct packed {
    logic gate_open;
  } tcf_stat_t;

  function automatic logic signed [33:0] atan_entry(input logic [StepW-1:0] i);
    logic signed [33:0] r;
    case (i)
      5'd0: r = 34'sd754974720;
      5'd1: r = 34'sd445687602;
      5'd2: r = 34'sd235489088;
      5'd3: r = 34'sd119537938;
      5'd4: r = 34'sd60000934;
      5'd5: r = 34'sd30029717;
      5'd6: r = 34'sd15018523;
      5'd7: r = 34'sd7509720;
      5'd8: r = 34'sd3754917;
      5'd9: r = 34'sd1877466;
      5'd10: r = 34'sd938734;
      5'd11: r = 34'sd469367;
      5'd12: r = 34'sd234684;
      5'd13: r = 34'sd117342;
      5'd14: r = 34'sd58671;
      5'd15: r = 34'sd29335;
      5'd16: r = 34'sd14668;
      5'd17: r = 34'sd7334;
      5'd18: r = 34'sd3667;
      5'd19: r = 34'sd1833;
      5'd20: r = 34'sd917;
      5'd21: r = 34'sd458;
      5'd22: r = 34'sd229;
      5'd23: r = 34'sd115;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    if (v > 50'sd2147483647) return 32'sh7fffffff;
    if (v < -50'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

FILE: hdl/tcf_ctrl.sv
// Controller state machine of the tilt filter: sequences integrate, gate,
// two parallel CORDIC passes, blend and output. Depends on tcf_pkg.
module tcf_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_fire,
  input  logic out_busy,
  input  tcf_pkg::tcf_stat_t stat,
  output logic in_ready,
  output logic out_load,
  output tcf_pkg::tcf_cmd_t cmd
);
  import tcf_pkg::*;

  tcf_state_t state, state_next;
  logic [StepW-1:0] step, step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step <= '0;
    end else begin
      state <= state_next;
      step <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next = step;
    case (state)
      ST_IDLE: if (in_fire) state_next = ST_INTEG;
      ST_INTEG: state_next = ST_GATE;
      ST_GATE: state_next = stat.gate_open ? ST_CSETUP : ST_IDLE;
      ST_CSETUP: begin
        state_next = ST_CITER;
        step_next = '0;
      end
      ST_CITER: begin
        step_next = step + 1'b1;
        if (step == StepW'(CordicSteps - 1)) state_next = ST_BLEND;
      end
      ST_BLEND: state_next = ST_OUT;
      ST_OUT: if (!out_busy) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.step = step;
    in_ready = (state == ST_IDLE);
    out_load = 1'b0;
    cmd.load = (state == ST_IDLE) && in_fire;
    case (state)
      ST_INTEG: begin
        cmd.integ = 1'b1;
        cmd.gate = 1'b1;
      end
      ST_CSETUP: cmd.csetup = 1'b1;
      ST_CITER: cmd.citer = 1'b1;
      ST_BLEND: cmd.blend = 1'b1;
      ST_OUT: out_load = !out_busy;
      default: ;
    endcase
  end
endmodule

FILE: hdl/tcf_datapath.sv
// Datapath of the tilt filter: sample registers, integrators, gate check,
// two CORDIC vectoring units and blend. Depends on tcf_pkg.
module tcf_datapath (
  input  logic clk,
  input  logic rst,
  input  tcf_pkg::tcf_cmd_t cmd,
  input  logic [79:0] sample,
  input  logic [31:0] gyro_gain,
  input  logic [16:0] blend_alpha,
  input  logic [16:0] gate_low,
  input  logic [16:0] gate_high,
  output tcf_pkg::tcf_stat_t stat,
  output logic signed [31:0] pitch_est,
  output logic signed [31:0] roll_est
);
  import tcf_pkg::*;

  logic signed [15:0] ax, ay, az;
  logic signed [48:0] incp, incr;
  logic gate_open;
  // CORDIC lanes: 0 = pitch atan2(ay,az), 1 = roll atan2(ax,az)
  logic signed [34:0] cx [2], cy [2];
  logic signed [33:0] cz [2];
  logic zero_vec [2];
  logic signed [33:0] atab;
  logic signed [17:0] alpha;

  assign atab = atan_entry(cmd.step);
  assign alpha = (blend_alpha > 17'd65536) ? 18'sd65536 : $signed({1'b0, blend_alpha});
  assign stat.gate_open = gate_open;

  function automatic logic signed [31:0] rnd_angle(input logic signed [33:0] z);
    logic signed [33:0] t;
    t = z + 34'sd128;
    return 32'(t >>> (TableFrac - AngleFracBits));
  endfunction

  function automatic logic signed [31:0] do_blend(input logic signed [31:0] e,
      input logic signed [31:0] a, input logic signed [17:0] al);
    logic signed [49:0] v;
    logic signed [17:0] bl;
    bl = 18'sd65536 - al;
    v = 50'(al) * 50'(e) + 50'(bl) * 50'(a) + 50'sd32768;
    return sat32(v >>> 16);
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ax <= sample[47:32];
      ay <= sample[63:48];
      az <= sample[79:64];
    end
    if (cmd.load) begin
      incp <= 49'(($signed(sample[15:0]) * $signed({1'b0, gyro_gain})
              + 49'sd2147483648) >>> 32);
      incr <= 49'(($signed(sample[31:16]) * $signed({1'b0, gyro_gain})
              + 49'sd2147483648) >>> 32);
    end
    if (cmd.gate) begin : gate_blk
      logic signed [17:0] s;
      logic [17:0] m;
      s = 18'(ax) + 18'(ay) + 18'(az);
      m = s[17] ? 18'(-s) : 18'(s);
      gate_open <= (m > {1'b0, gate_low}) && (m < {1'b0, gate_high});
    end
    if (cmd.csetup) begin
      for (int k = 0; k < 2; k++) begin : lane
        logic signed [34:0] x, y;
        x = 35'(az) <<< 16;
        y = (k == 0) ? (35'(ay) <<< 16) : (35'(ax) <<< 16);
        zero_vec[k] <= (x == 0) && (y == 0);
        if (x < 0) begin
          if (y >= 0) begin
            cx[k] <= y; cy[k] <= -x; cz[k] <= 34'sd1509949440;
          end else begin
            cx[k] <= -y; cy[k] <= x; cz[k] <= -34'sd1509949440;
          end
        end else begin
          cx[k] <= x; cy[k] <= y; cz[k] <= '0;
        end
      end
    end
    if (cmd.citer) begin
      for (int k = 0; k < 2; k++) begin
        if (cy[k] >= 0) begin
          cx[k] <= cx[k] + (cy[k] >>> cmd.step);
          cy[k] <= cy[k] - (cx[k] >>> cmd.step);
          cz[k] <= cz[k] + atab;
        end else begin
          cx[k] <= cx[k] - (cy[k] >>> cmd.step);
          cy[k] <= cy[k] + (cx[k] >>> cmd.step);
          cz[k] <= cz[k] - atab;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pitch_est <= '0;
      roll_est <= '0;
    end else if (cmd.integ) begin
      pitch_est <= sat32(50'(pitch_est) + 50'(incp));
      roll_est <= sat32(50'(roll_est) + 50'(incr));
    end else if (cmd.blend) begin
      pitch_est <= do_blend(pitch_est, zero_vec[0] ? 32'sd0 : rnd_angle(cz[0]), alpha);
      roll_est <= do_blend(roll_est, zero_vec[1] ? 32'sd0 : rnd_angle(cz[1]), alpha);
    end
  end
endmodule

FILE: hdl/tilt_complementary_filter.sv
// Tilt complementary filter top level: configuration registers, stream
// ports and output register. Depends on tcf_pkg, tcf_ctrl, tcf_datapath.
//
// One IMU sample per item. The gyro rates are integrated into pitch and roll
// (signed Q16.16 degrees, saturated); when |ax+ay+az| lies strictly between
// gate_low and gate_high, both angles are blended with atan2 accelerometer
// angles and one result item is emitted, otherwise none. A new item is accepted
// only once the previous one is through; with the gate open, that includes the 16
// iterations of the two CORDIC units that run side by side. While the previous
// result still waits in the output register, hold until it is taken.
module tilt_complementary_filter (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [79:0] s_axis_tdata, // gyro_x, gyro_y, accel_x, accel_y, accel_z
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [63:0] m_axis_tdata, // pitch_angle, roll_angle
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [31:0] cfg_data
);
  import tcf_pkg::*;

  logic [31:0] gyro_gain;
  logic [16:0] blend_alpha, gate_low, gate_high;
  tcf_cmd_t cmd;
  tcf_stat_t stat;
  logic out_load, out_busy;
  logic signed [31:0] pitch_est, roll_est;

  always_ff @(posedge clk) begin
    if (rst) begin
      gyro_gain <= 32'd149922;
      blend_alpha <= 17'd64225;
      gate_low <= 17'd8192;
      gate_high <= 17'd32768;
    end else if (cfg_we) begin
      case (cfg_index)
        RegGyroGain: gyro_gain <= cfg_data;
        RegBlendAlpha: blend_alpha <= cfg_data[16:0];
        RegGateLow: gate_low <= cfg_data[16:0];
        RegGateHigh: gate_high <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  assign out_busy = m_axis_tvalid && !m_axis_tready;

  tcf_ctrl u_ctrl (
    .clk, .rst,
    .in_fire(s_axis_tvalid && s_axis_tready),
    .out_busy, .stat,
    .in_ready(s_axis_tready),
    .out_load, .cmd
  );

  tcf_datapath u_dp (
    .clk, .rst, .cmd,
    .sample(s_axis_tdata),
    .gyro_gain, .blend_alpha, .gate_low, .gate_high,
    .stat, .pitch_est, .roll_est
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) m_axis_tdata <= {roll_est, pitch_est};
  end
endmodule
